// ===== rtl/ezyx_pkg.sv =====
// shared types, constants and tables for the z-y-x euler angle to rotation matrix pipeline
// no dependencies; used by every module of the block
`default_nettype none

package ezyx_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ENTRY_FRAC_BITS = 14;
  localparam int WORK_FRAC       = 30;
  localparam int CORDIC_STEPS    = 32;

  // angle magnitude after scaling to the working q30 format
  localparam int ANG_SH    = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int MAG_W     = 16 + ANG_SH;
  // quotient bits of the 2*pi range reduction
  localparam int RED_STEPS = (MAG_W > 33) ? (MAG_W - 33) : 1;
  localparam int RW        = ((MAG_W > 34) ? MAG_W : 34) + RED_STEPS;

  localparam int ZW = 35;            // cordic angle
  localparam int XW = 34;            // cordic x / y
  localparam int SW = 32;            // sine / cosine q30
  localparam int PW = 2 * SW;        // raw product
  localparam int EW = 34;            // entry sums
  localparam int ENT_SH = WORK_FRAC - ENTRY_FRAC_BITS;

  localparam logic signed [ZW-1:0] PI_Q      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q  = 35'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q = 35'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q    = 34'sd652032874;
  localparam logic [63:0]          TWO_PI_64 = 64'd6746518852;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_t;

  function automatic logic signed [ZW-1:0] atan_q(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 35'sh3243F6A8;
      5'd1:  r = 35'sh1DAC6705;
      5'd2:  r = 35'sh0FADBAFC;
      5'd3:  r = 35'sh07F56EA6;
      5'd4:  r = 35'sh03FEAB76;
      5'd5:  r = 35'sh01FFD55B;
      5'd6:  r = 35'sh00FFFAAA;
      5'd7:  r = 35'sh007FFF55;
      5'd8:  r = 35'sh003FFFEA;
      5'd9:  r = 35'sh001FFFFD;
      5'd10: r = 35'sh000FFFFF;
      5'd11: r = 35'sh0007FFFF;
      5'd12: r = 35'sh0003FFFF;
      5'd13: r = 35'sh0001FFFF;
      5'd14: r = 35'sh0000FFFF;
      5'd15: r = 35'sh00007FFF;
      5'd16: r = 35'sh00003FFF;
      5'd17: r = 35'sh00001FFF;
      5'd18: r = 35'sh00000FFF;
      5'd19: r = 35'sh000007FF;
      5'd20: r = 35'sh000003FF;
      5'd21: r = 35'sh000001FF;
      5'd22: r = 35'sh000000FF;
      5'd23: r = 35'sh0000007F;
      5'd24: r = 35'sh0000003F;
      5'd25: r = 35'sh0000001F;
      5'd26: r = 35'sh0000000F;
      5'd27: r = 35'sh00000008;
      5'd28: r = 35'sh00000004;
      5'd29: r = 35'sh00000002;
      5'd30: r = 35'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/euler_zyx_to_rotation_matrix.sv =====
// z-y-x euler angles to rotation matrix: range reduction, three pipelined cordics, products
// depends on ezyx_pkg
`default_nettype none

// Takes one yaw/pitch/roll triple (signed q3.13 radians) per cycle and returns the nine
// row-major entries of Rz(yaw)*Ry(pitch)*Rx(roll) in signed q1.14, saturated at +-1.0.
// The pipeline has one input stage, the 2*pi reduction stages, a wrap and a quadrant fold
// stage, 32 unrolled cordic stages (one micro-rotation each), a sign stage and five
// product/rounding stages. Throughput is one transaction per cycle; the whole pipeline
// holds while a finished result waits on out_ready.
module euler_zyx_to_rotation_matrix (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ezyx_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ezyx_pkg::out_t     out_data
);

  localparam int RS = ezyx_pkg::RED_STEPS;
  localparam int NS = ezyx_pkg::CORDIC_STEPS;
  localparam int NV = RS + 41;
  localparam int RW = ezyx_pkg::RW;
  localparam int ZW = ezyx_pkg::ZW;
  localparam int XW = ezyx_pkg::XW;
  localparam int SW = ezyx_pkg::SW;
  localparam int PW = ezyx_pkg::PW;
  localparam int EW = ezyx_pkg::EW;
  localparam int ESH = ezyx_pkg::ENT_SH;
  localparam logic signed [EW-1:0] ENT_RND =
    (ESH == 0) ? '0 : (EW'(1) << ((ESH > 0) ? (ESH - 1) : 0));
  localparam logic signed [EW-1:0] ENT_ONE = EW'(1) << ezyx_pkg::ENTRY_FRAC_BITS;
  localparam logic signed [PW-1:0] MUL_RND = PW'(1) << (ezyx_pkg::WORK_FRAC - 1);

  function automatic logic signed [SW-1:0] rnd_q(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + MUL_RND) >>> ezyx_pkg::WORK_FRAC;
    return t[SW-1:0];
  endfunction

  function automatic logic signed [15:0] entry_q(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    r = (v + ENT_RND) >>> ESH;
    if (r > ENT_ONE) r = ENT_ONE;
    if (r < -ENT_ONE) r = -ENT_ONE;
    return r[15:0];
  endfunction

  logic          en;
  logic [NV-1:0] vld_r;

  assign en        = !vld_r[NV-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  logic signed [15:0]   ang_in [3];
  logic signed [SW-1:0] sin_r  [3];
  logic signed [SW-1:0] cos_r  [3];

  assign ang_in[0] = in_data.yaw_angle;
  assign ang_in[1] = in_data.pitch_angle;
  assign ang_in[2] = in_data.roll_angle;

  for (genvar j = 0; j < 3; j++) begin : g_ang
    logic [RW-1:0]        mag_r  [RS+1];
    logic                 sgn_r  [RS+1];
    logic signed [ZW-1:0] wrap_r;
    logic signed [ZW-1:0] sa;
    logic signed [ZW-1:0] cz_r   [NS+1];
    logic signed [XW-1:0] cx_r   [NS+1];
    logic signed [XW-1:0] cy_r   [NS+1];
    logic                 flip_r [NS+1];
    logic [15:0]          abs_in;

    assign abs_in = ang_in[j][15] ? 16'(-ang_in[j]) : 16'(ang_in[j]);
    assign sa = sgn_r[RS] ? -ZW'(mag_r[RS]) : ZW'(mag_r[RS]);

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[0] <= RW'(abs_in) << ezyx_pkg::ANG_SH;
        sgn_r[0] <= ang_in[j][15];
        // sign-magnitude wrap into +-pi
        if (sa > ezyx_pkg::PI_Q) begin
          wrap_r <= sa - ezyx_pkg::TWO_PI_Q;
        end else if (sa < -ezyx_pkg::PI_Q) begin
          wrap_r <= sa + ezyx_pkg::TWO_PI_Q;
        end else begin
          wrap_r <= sa;
        end
        // fold into +-pi/2, negate both outputs at the end
        cx_r[0] <= ezyx_pkg::GAIN_Q;
        cy_r[0] <= '0;
        if (wrap_r > ezyx_pkg::HALF_PI_Q) begin
          cz_r[0]   <= wrap_r - ezyx_pkg::PI_Q;
          flip_r[0] <= 1'b1;
        end else if (wrap_r < -ezyx_pkg::HALF_PI_Q) begin
          cz_r[0]   <= wrap_r + ezyx_pkg::PI_Q;
          flip_r[0] <= 1'b1;
        end else begin
          cz_r[0]   <= wrap_r;
          flip_r[0] <= 1'b0;
        end
        cos_r[j] <= flip_r[NS] ? SW'(-cx_r[NS]) : SW'(cx_r[NS]);
        sin_r[j] <= flip_r[NS] ? SW'(-cy_r[NS]) : SW'(cy_r[NS]);
      end
    end

    // restoring remainder by 2*pi, one quotient bit per stage
    for (genvar r = 0; r < RS; r++) begin : g_red
      localparam logic [RW-1:0] TPK = RW'(ezyx_pkg::TWO_PI_64 << (RS - 1 - r));
      always_ff @(posedge clk) begin
        if (en) begin
          mag_r[r+1] <= (mag_r[r] >= TPK) ? (mag_r[r] - TPK) : mag_r[r];
          sgn_r[r+1] <= sgn_r[r];
        end
      end
    end

    for (genvar i = 0; i < NS; i++) begin : g_cordic
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      assign dx = cy_r[i] >>> i;
      assign dy = cx_r[i] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          flip_r[i+1] <= flip_r[i];
          if (!cz_r[i][ZW-1]) begin
            cx_r[i+1] <= cx_r[i] - dx;
            cy_r[i+1] <= cy_r[i] + dy;
            cz_r[i+1] <= cz_r[i] - ezyx_pkg::atan_q(5'(i));
          end else begin
            cx_r[i+1] <= cx_r[i] + dx;
            cy_r[i+1] <= cy_r[i] - dy;
            cz_r[i+1] <= cz_r[i] + ezyx_pkg::atan_q(5'(i));
          end
        end
      end
    end
  end

  // product stages
  logic signed [SW-1:0] sy, cy, sp, cp, sr, cr;
  assign sy = sin_r[0];
  assign cy = cos_r[0];
  assign sp = sin_r[1];
  assign cp = cos_r[1];
  assign sr = sin_r[2];
  assign cr = cos_r[2];

  logic signed [PW-1:0] a_cysp_r, a_sysp_r, a_cycp_r, a_sycr_r, a_sysr_r;
  logic signed [PW-1:0] a_sycp_r, a_cycr_r, a_cysr_r, a_cpsr_r, a_cpcr_r;
  logic signed [SW-1:0] a_sp_r, a_sr_r, a_cr_r;

  logic signed [SW-1:0] b_cysp_r, b_sysp_r, b_cycp_r, b_sycr_r, b_sysr_r;
  logic signed [SW-1:0] b_sycp_r, b_cycr_r, b_cysr_r, b_cpsr_r, b_cpcr_r;
  logic signed [SW-1:0] b_sp_r, b_sr_r, b_cr_r;

  logic signed [PW-1:0] c_q1_r, c_q2_r, c_q3_r, c_q4_r;
  logic signed [SW-1:0] c_cycp_r, c_sycr_r, c_sysr_r, c_sycp_r, c_cycr_r;
  logic signed [SW-1:0] c_cysr_r, c_cpsr_r, c_cpcr_r, c_sp_r;

  logic signed [EW-1:0] e_r [9];
  ezyx_pkg::out_t       out_r;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_cysp_r <= PW'(cy) * PW'(sp);
      a_sysp_r <= PW'(sy) * PW'(sp);
      a_cycp_r <= PW'(cy) * PW'(cp);
      a_sycr_r <= PW'(sy) * PW'(cr);
      a_sysr_r <= PW'(sy) * PW'(sr);
      a_sycp_r <= PW'(sy) * PW'(cp);
      a_cycr_r <= PW'(cy) * PW'(cr);
      a_cysr_r <= PW'(cy) * PW'(sr);
      a_cpsr_r <= PW'(cp) * PW'(sr);
      a_cpcr_r <= PW'(cp) * PW'(cr);
      a_sp_r   <= sp;
      a_sr_r   <= sr;
      a_cr_r   <= cr;

      b_cysp_r <= rnd_q(a_cysp_r);
      b_sysp_r <= rnd_q(a_sysp_r);
      b_cycp_r <= rnd_q(a_cycp_r);
      b_sycr_r <= rnd_q(a_sycr_r);
      b_sysr_r <= rnd_q(a_sysr_r);
      b_sycp_r <= rnd_q(a_sycp_r);
      b_cycr_r <= rnd_q(a_cycr_r);
      b_cysr_r <= rnd_q(a_cysr_r);
      b_cpsr_r <= rnd_q(a_cpsr_r);
      b_cpcr_r <= rnd_q(a_cpcr_r);
      b_sp_r   <= a_sp_r;
      b_sr_r   <= a_sr_r;
      b_cr_r   <= a_cr_r;

      c_q1_r   <= PW'(b_cysp_r) * PW'(b_sr_r);
      c_q2_r   <= PW'(b_cysp_r) * PW'(b_cr_r);
      c_q3_r   <= PW'(b_sysp_r) * PW'(b_sr_r);
      c_q4_r   <= PW'(b_sysp_r) * PW'(b_cr_r);
      c_cycp_r <= b_cycp_r;
      c_sycr_r <= b_sycr_r;
      c_sysr_r <= b_sysr_r;
      c_sycp_r <= b_sycp_r;
      c_cycr_r <= b_cycr_r;
      c_cysr_r <= b_cysr_r;
      c_cpsr_r <= b_cpsr_r;
      c_cpcr_r <= b_cpcr_r;
      c_sp_r   <= b_sp_r;

      e_r[0] <= EW'(c_cycp_r);
      e_r[1] <= EW'(rnd_q(c_q1_r)) - EW'(c_sycr_r);
      e_r[2] <= EW'(rnd_q(c_q2_r)) + EW'(c_sysr_r);
      e_r[3] <= EW'(c_sycp_r);
      e_r[4] <= EW'(rnd_q(c_q3_r)) + EW'(c_cycr_r);
      e_r[5] <= EW'(rnd_q(c_q4_r)) - EW'(c_cysr_r);
      e_r[6] <= -EW'(c_sp_r);
      e_r[7] <= EW'(c_cpsr_r);
      e_r[8] <= EW'(c_cpcr_r);

      out_r.m00 <= entry_q(e_r[0]);
      out_r.m01 <= entry_q(e_r[1]);
      out_r.m02 <= entry_q(e_r[2]);
      out_r.m10 <= entry_q(e_r[3]);
      out_r.m11 <= entry_q(e_r[4]);
      out_r.m12 <= entry_q(e_r[5]);
      out_r.m20 <= entry_q(e_r[6]);
      out_r.m21 <= entry_q(e_r[7]);
      out_r.m22 <= entry_q(e_r[8]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ezyx_checker.sv =====
// port-level checks for euler_zyx_to_rotation_matrix, attached by bind
// depends on ezyx_pkg
`default_nettype none

module ezyx_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire ezyx_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire ezyx_pkg::out_t out_data
);

  localparam logic signed [15:0] ONE = 16'(1 << ezyx_pkg::ENTRY_FRAC_BITS);
  localparam bit NARROW = (ezyx_pkg::ENTRY_FRAC_BITS <= 14);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // pipeline is empty right after reset
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result present after reset");

  // input side only stalls when a result is stuck at the output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output");

  // diagonal entries stay within the saturation bounds
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NARROW |-> out_data.m00 <= ONE && out_data.m00 >= -ONE &&
      out_data.m11 <= ONE && out_data.m11 >= -ONE &&
      out_data.m22 <= ONE && out_data.m22 >= -ONE)
    else $error("matrix entry out of range");

endmodule

bind euler_zyx_to_rotation_matrix ezyx_checker u_ezyx_checker (.*);

`default_nettype wire
